[hdl/sibt_pkg.sv]
// Shared types, codes and helpers for the sparse image block translator.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package sibt_pkg;

  // Item functions
  localparam logic [1:0] FUNC_LOAD      = 2'd0;
  localparam logic [1:0] FUNC_FINISH    = 2'd1;
  localparam logic [1:0] FUNC_TRANSLATE = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_STORED   = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;

  // Layout codes
  localparam logic [1:0] LAYOUT_PER_BLOCK = 2'd0;
  localparam logic [1:0] LAYOUT_PER_STRIP = 2'd2;

  // Register indexes (byte address is 8 times the index)
  localparam logic [2:0] REG_TOTAL_BYTES  = 3'd0;
  localparam logic [2:0] REG_BLOCK_SIZE   = 3'd1;
  localparam logic [2:0] REG_TOTAL_BLOCKS = 3'd2;
  localparam logic [2:0] REG_USED_BLOCKS  = 3'd3;
  localparam logic [2:0] REG_DATA_OFFSET  = 3'd4;
  localparam logic [2:0] REG_LAYOUT_MODE  = 3'd5;
  localparam logic [2:0] REG_TRAILER_SIZE = 3'd6;
  localparam logic [2:0] REG_BPS          = 3'd7;

  // Sequencer states
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CHECK = 14'b00000000000010,
    S_CLASS = 14'b00000000000100,
    S_DIV   = 14'b00000000001000,
    S_RD    = 14'b00000000010000,
    S_TEST  = 14'b00000000100000,
    S_RANK  = 14'b00000001000000,
    S_SUM   = 14'b00000010000000,
    S_MUL   = 14'b00000100000000,
    S_SDIV  = 14'b00001000000000,
    S_BASE  = 14'b00010000000000,
    S_POS   = 14'b00100000000000,
    S_EMIT  = 14'b01000000000000,
    S_SPARE = 14'b10000000000000
  } state_e;

  // Count set bits of one byte
  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    a = v - ((v >> 1) & 8'h55);
    b = (a & 8'h33) + ((a >> 2) & 8'h33);
    c = (b + (b >> 4)) & 8'h0f;
    return c[3:0];
  endfunction

endpackage

[hdl/sibt_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Stand-alone; used by the translator top level for block and strip division.
`timescale 1ns / 1ps

module sibt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [26:0] divisor_i,
  output logic        done_o,
  output logic [47:0] quot_o,
  output logic [26:0] rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] quot_q, quot_d;
  logic [26:0] rem_q, rem_d;
  logic [26:0] div_q, div_d;
  logic [27:0] trial;
  logic        ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial  = {rem_q, quot_q[47]};
    ge     = trial >= {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd47;
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[46:0], ge};
      rem_d  = ge ? 27'(trial - {1'b0, div_q}) : trial[26:0];
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

[hdl/sparse_image_block_translator.sv]
// Top level of the sparse image block translator: config registers, bitmap and
// checkpoint memories, and the translate sequencer. Depends on sibt_pkg, sibt_div.
`timescale 1ns / 1ps

// Maps logical byte reads of a sparse image onto stored file offsets. Load items
// (func 0) write one bitmap byte and update the running used count, writing a
// rank checkpoint at each group start. A translate item splits its offset with
// the 48-step divider unless it is zero fill beyond the logical blocks; for a
// stored block it then walks up to GROUP_BLOCKS/8 bitmap bytes from the group
// start through the single bitmap read port, and layout 2 runs the divider once
// more for the strip. One item is in flight at a time, and the next is taken
// while a result waits on the output. GROUP_BLOCKS must be a power of two. The
// memories need no clearing after reset.
module sparse_image_block_translator
  import sibt_pkg::*;
#(
  parameter int BITMAP_BYTES = 65536,
  parameter int GROUP_BLOCKS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] bitmap_index_i,
  input  logic [7:0]  bitmap_byte_i,
  input  logic [47:0] byte_offset_i,
  input  logic [31:0] request_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] byte_count_o,
  output logic [47:0] stored_offset_o,
  output logic [18:0] stored_block_o,
  output logic [18:0] strip_index_o
);

  localparam int BW         = $clog2(BITMAP_BYTES);
  localparam int GSH        = $clog2(GROUP_BLOCKS);
  localparam int RANK_DEPTH = (BITMAP_BYTES * 8 + GROUP_BLOCKS - 1) / GROUP_BLOCKS;
  localparam int CW         = (RANK_DEPTH > 1) ? $clog2(RANK_DEPTH) : 1;

  // Configuration registers
  logic [47:0] total_bytes_q;
  logic [26:0] block_size_q;
  logic [19:0] total_blocks_q;
  logic [19:0] used_blocks_q;
  logic [47:0] data_offset_q;
  logic [1:0]  layout_mode_q;
  logic [3:0]  trailer_size_q;
  logic [19:0] bps_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_bytes_q  <= '0;
      block_size_q   <= 27'd4096;
      total_blocks_q <= 20'd1;
      used_blocks_q  <= '0;
      data_offset_q  <= '0;
      layout_mode_q  <= 2'd1;
      trailer_size_q <= 4'd4;
      bps_q          <= 20'd1;
    end else if (cfg_we) begin
      case (paddr[5:3])
        REG_TOTAL_BYTES:  total_bytes_q  <= pwdata[47:0];
        REG_BLOCK_SIZE:   block_size_q   <= pwdata[26:0];
        REG_TOTAL_BLOCKS: total_blocks_q <= pwdata[19:0];
        REG_USED_BLOCKS:  used_blocks_q  <= pwdata[19:0];
        REG_DATA_OFFSET:  data_offset_q  <= pwdata[47:0];
        REG_LAYOUT_MODE:  layout_mode_q  <= pwdata[1:0];
        REG_TRAILER_SIZE: trailer_size_q <= pwdata[3:0];
        REG_BPS:          bps_q          <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    case (paddr[5:3])
      REG_TOTAL_BYTES:  prdata = {16'b0, total_bytes_q};
      REG_BLOCK_SIZE:   prdata = {37'b0, block_size_q};
      REG_TOTAL_BLOCKS: prdata = {44'b0, total_blocks_q};
      REG_USED_BLOCKS:  prdata = {44'b0, used_blocks_q};
      REG_DATA_OFFSET:  prdata = {16'b0, data_offset_q};
      REG_LAYOUT_MODE:  prdata = {62'b0, layout_mode_q};
      REG_TRAILER_SIZE: prdata = {60'b0, trailer_size_q};
      REG_BPS:          prdata = {44'b0, bps_q};
      default:          prdata = '0;
    endcase
  end

  // Sequencer and datapath registers
  state_e      state_q, state_d;
  logic [19:0] run_cnt_q, run_cnt_d;
  logic [47:0] off_q, off_d;
  logic [31:0] len_q, len_d;
  logic [46:0] logical_q, logical_d;
  logic [19:0] blk_q, blk_d;
  logic [26:0] inb_q, inb_d;
  logic [16:0] walk_q, walk_d;
  logic        issuing_q, issuing_d;
  logic        pend_q, pend_d;
  logic        pend_last_q, pend_last_d;
  logic [19:0] acc_q, acc_d;
  logic [19:0] sb_q, sb_d;
  logic [47:0] prod_q, prod_d;
  logic [19:0] strip_q, strip_d;
  logic [47:0] base_q, base_d;
  logic [23:0] stoff_q, stoff_d;
  logic [2:0]  res_status_q, res_status_d;
  logic [31:0] res_count_q, res_count_d;
  logic [47:0] res_soff_q, res_soff_d;
  logic [18:0] res_sblk_q, res_sblk_d;
  logic [18:0] res_strip_q, res_strip_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_status_q;
  logic [31:0] out_count_q;
  logic [47:0] out_soff_q;
  logic [18:0] out_sblk_q;
  logic [18:0] out_strip_q;
  logic        out_load;

  // Memories
  logic [7:0]    bitmap_mem [BITMAP_BYTES];
  logic [19:0]   ckpt_mem [RANK_DEPTH];
  logic          bm_we;
  logic [BW-1:0] bm_waddr;
  logic [BW-1:0] bm_raddr;
  logic [7:0]    bm_rdata_q;
  logic          ck_we;
  logic [CW-1:0] ck_waddr;
  logic [19:0]   ck_wdata;
  logic [CW-1:0] ck_raddr;
  logic [19:0]   ck_rdata_q;

  // Divider
  logic        div_start;
  logic [47:0] div_dividend;
  logic [26:0] div_divisor;
  logic        div_done;
  logic [47:0] div_quot;
  logic [26:0] div_rem;

  sibt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Helper values
  logic        accept;
  logic [18:0] lblk;
  logic [7:0]  lmask;
  logic [19:0] lbase;
  logic        idx_ok;
  logic [47:0] avail;
  logic [26:0] rest;
  logic [16:0] first_byte;
  logic [16:0] last_byte;
  logic        in_store;
  logic [7:0]  tail_mask;
  logic [27:0] mult;
  logic [19:0] bps_eff;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign lblk       = {bitmap_index_i, 3'b000};
  assign idx_ok     = 32'(bitmap_index_i) < 32'(BITMAP_BYTES);
  assign lbase      = (bitmap_index_i == '0) ? 20'd0 : run_cnt_q;
  assign avail      = total_bytes_q - off_q;
  assign rest       = block_size_q - div_rem;
  assign first_byte = 17'((blk_q >> GSH) << (GSH - 3));
  assign last_byte  = blk_q[19:3];
  assign in_store   = 32'(last_byte) < 32'(BITMAP_BYTES);
  assign tail_mask  = 8'((9'd1 << blk_q[2:0]) - 9'd1);
  assign mult       = (layout_mode_q == LAYOUT_PER_BLOCK) ?
                      28'(block_size_q) + 28'(trailer_size_q) : 28'(block_size_q);
  assign bps_eff    = (bps_q == '0) ? 20'd1 : bps_q;
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  // Flag bitmap bits that fall below the block total
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      lmask[k] = {1'b0, bitmap_index_i, 3'(k)} < total_blocks_q;
    end
  end

  // Load path: bitmap write and checkpoint at each group start
  assign bm_we    = accept && (func_i == FUNC_LOAD) && idx_ok;
  assign bm_waddr = BW'(bitmap_index_i);
  assign ck_we    = bm_we && lmask[0] && (lblk[GSH-1:0] == '0);
  assign ck_waddr = CW'(lblk >> GSH);
  assign ck_wdata = lbase;
  assign bm_raddr = (state_q == S_RANK) ? BW'(walk_q) : BW'(last_byte);
  assign ck_raddr = CW'(blk_q >> GSH);

  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bitmap_mem[bm_waddr] <= bitmap_byte_i;
    end
    bm_rdata_q <= bitmap_mem[bm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ck_we) begin
      ckpt_mem[ck_waddr] <= ck_wdata;
    end
    ck_rdata_q <= ckpt_mem[ck_raddr];
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    run_cnt_d    = run_cnt_q;
    off_d        = off_q;
    len_d        = len_q;
    logical_d    = logical_q;
    blk_d        = blk_q;
    inb_d        = inb_q;
    walk_d       = walk_q;
    issuing_d    = issuing_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    acc_d        = acc_q;
    sb_d         = sb_q;
    prod_d       = prod_q;
    strip_d      = strip_q;
    base_d       = base_q;
    stoff_d      = stoff_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    res_soff_d   = res_soff_q;
    res_sblk_d   = res_sblk_q;
    res_strip_d  = res_strip_q;
    div_start    = 1'b0;
    div_dividend = off_q;
    div_divisor  = block_size_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_ACCEPTED;
          res_count_d  = '0;
          res_soff_d   = '0;
          res_sblk_d   = '0;
          res_strip_d  = '0;
          off_d        = byte_offset_i;
          len_d        = request_length_i;
          state_d      = S_EMIT;
          case (func_i)
            FUNC_LOAD: begin
              if (idx_ok) begin
                run_cnt_d = lbase + 20'(pop8(bitmap_byte_i & lmask));
              end else begin
                res_status_d = ST_RANGE;
              end
            end
            FUNC_FINISH: begin
              res_status_d = (run_cnt_q == used_blocks_q) ? ST_ACCEPTED : ST_MISMATCH;
            end
            FUNC_TRANSLATE: begin
              state_d = S_CHECK;
            end
            default: begin
              res_status_d = ST_RANGE;
            end
          endcase
        end
      end
      // Range check and logical size
      S_CHECK: begin
        logical_d = 47'(total_blocks_q * block_size_q);
        if (off_q > total_bytes_q || 48'(len_q) > avail) begin
          res_status_d = ST_RANGE;
          state_d      = S_EMIT;
        end else if (len_q == '0) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_CLASS;
        end
      end
      // Zero fill beyond the logical blocks, else split the offset
      S_CLASS: begin
        if (off_q >= 48'(logical_q)) begin
          res_status_d = ST_ZERO;
          res_count_d  = len_q;
          state_d      = S_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          blk_d       = div_quot[19:0];
          inb_d       = div_rem;
          res_count_d = (32'(rest) > len_q) ? len_q : 32'(rest);
          state_d     = S_RD;
        end
      end
      // Bitmap byte of the block is being read
      S_RD: begin
        state_d = S_TEST;
      end
      S_TEST: begin
        if (!(in_store && bm_rdata_q[blk_q[2:0]])) begin
          res_status_d = ST_ZERO;
          state_d      = S_EMIT;
        end else begin
          walk_d    = first_byte;
          issuing_d = 1'b1;
          pend_d    = 1'b0;
          acc_d     = '0;
          state_d   = S_RANK;
        end
      end
      // Walk bitmap bytes from the group start up to the block
      S_RANK: begin
        pend_d = issuing_q;
        if (issuing_q) begin
          pend_last_d = (walk_q == last_byte);
          walk_d      = walk_q + 17'd1;
          if (walk_q == last_byte) begin
            issuing_d = 1'b0;
          end
        end
        if (pend_q) begin
          acc_d = acc_q + 20'(pop8(bm_rdata_q & (pend_last_q ? tail_mask : 8'hff)));
          if (pend_last_q) begin
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        sb_d    = ck_rdata_q + acc_q;
        state_d = S_MUL;
      end
      // Scale the rank and pick the strip
      S_MUL: begin
        prod_d     = 48'(sb_q * mult);
        res_sblk_d = sb_q[18:0];
        state_d    = S_BASE;
        if (layout_mode_q == LAYOUT_PER_BLOCK) begin
          strip_d = sb_q;
        end else if (layout_mode_q == LAYOUT_PER_STRIP) begin
          div_start    = 1'b1;
          div_dividend = 48'(sb_q);
          div_divisor  = 27'(bps_eff);
          state_d      = S_SDIV;
        end else begin
          strip_d = '0;
        end
      end
      S_SDIV: begin
        div_dividend = 48'(sb_q);
        div_divisor  = 27'(bps_eff);
        if (div_done) begin
          strip_d = div_quot[19:0];
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        base_d  = data_offset_q + prod_q;
        stoff_d = (layout_mode_q == LAYOUT_PER_STRIP) ? 24'(strip_q * trailer_size_q) : '0;
        state_d = S_POS;
      end
      S_POS: begin
        res_soff_d   = base_q + 48'(28'(stoff_q) + 28'(inb_q));
        res_strip_d  = strip_q[18:0];
        res_status_d = ST_STORED;
        state_d      = S_EMIT;
      end
      // Hand the result to the output register once it is free
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: hold until the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_cnt_q   <= '0;
      issuing_q   <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_cnt_q   <= run_cnt_d;
      issuing_q   <= issuing_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q        <= off_d;
    len_q        <= len_d;
    logical_q    <= logical_d;
    blk_q        <= blk_d;
    inb_q        <= inb_d;
    walk_q       <= walk_d;
    acc_q        <= acc_d;
    sb_q         <= sb_d;
    prod_q       <= prod_d;
    strip_q      <= strip_d;
    base_q       <= base_d;
    stoff_q      <= stoff_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    res_soff_q   <= res_soff_d;
    res_sblk_q   <= res_sblk_d;
    res_strip_q  <= res_strip_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_count_q  <= res_count_q;
      out_soff_q   <= res_soff_q;
      out_sblk_q   <= res_sblk_q;
      out_strip_q  <= res_strip_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign byte_count_o    = out_count_q;
  assign stored_offset_o = out_soff_q;
  assign stored_block_o  = out_sblk_q;
  assign strip_index_o   = out_strip_q;

endmodule

[tb/tb_sparse_image_block_translator.sv]
// Self-checking testbench for the sparse image block translator: directed table,
// then randomized load/finish/translate phases checked against a local predictor.
// Depends on sibt_pkg and the sparse_image_block_translator RTL.
`timescale 1ns / 1ps

module tb_sparse_image_block_translator;
  import sibt_pkg::*;

  localparam int          GROUP      = 4096;
  localparam int          STORE      = 65536;
  localparam int          CKPTS      = 128;
  localparam int          WD_LIMIT   = 20000;
  localparam int          ROWS       = 25;
  localparam int          SPLIT      = 7;
  localparam logic [47:0] M48        = 48'hFFFF_FFFF_FFFF;
  localparam logic [1:0]  FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] count;
    logic [47:0] soff;
    logic [18:0] sblk;
    logic [18:0] strip;
  } xlate_t;

  typedef struct {
    logic [1:0]  f;
    logic [15:0] idx;
    logic [7:0]  bt;
    logic [47:0] off;
    logic [31:0] len;
    bit          typed;
    logic [2:0]  st;
    logic [31:0] cnt;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [15:0] bitmap_index_i;
  logic [7:0]  bitmap_byte_i;
  logic [47:0] byte_offset_i;
  logic [31:0] request_length_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [31:0] byte_count_o;
  logic [47:0] stored_offset_o;
  logic [18:0] stored_block_o;
  logic [18:0] strip_index_o;

  sparse_image_block_translator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .bitmap_index_i   (bitmap_index_i),
    .bitmap_byte_i    (bitmap_byte_i),
    .byte_offset_i    (byte_offset_i),
    .request_length_i (request_length_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .byte_count_o     (byte_count_o),
    .stored_offset_o  (stored_offset_o),
    .stored_block_o   (stored_block_o),
    .strip_index_o    (strip_index_o)
  );

  // Mirror of the bitmap, checkpoints, running count and registers
  logic [7:0]  bm_mirror [STORE];
  bit          bm_written [STORE];
  logic [19:0] ckpt_mirror [CKPTS];
  bit          ckpt_written [CKPTS];
  logic [19:0] used_count = '0;
  logic [47:0] c_tbytes = '0;
  logic [26:0] c_bsize = 27'd4096;
  logic [19:0] c_tblk = 20'd1;
  logic [19:0] c_used = '0;
  logic [47:0] c_doff = '0;
  logic [1:0]  c_layout = 2'd1;
  logic [3:0]  c_tsz = 4'd4;
  logic [19:0] c_bps = 20'd1;

  xlate_t pending_xlate [$];
  xlate_t head;
  int     errors = 0;
  int     idle_cycles = 0;
  int     rdy_hold = 0;
  bit     quiet = 0;

  row_t plan [ROWS] = '{
    // reset registers: empty device
    '{FUNC_FINISH,    16'd0, 8'h00, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_TRANSLATE, 16'd0, 8'h00, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_TRANSLATE, 16'd0, 8'h00, 48'd0, 32'd1,          1, ST_RANGE,    32'd0},
    '{FUNC_TRANSLATE, 16'd0, 8'h00, M48,   32'hFFFFFFFF,   1, ST_RANGE,    32'd0},
    '{FUNC_SPARE,     16'hFFFF, 8'hFF, M48, 32'hFFFFFFFF,  1, ST_RANGE,    32'd0},
    '{FUNC_LOAD,      16'd0, 8'hFF, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_FINISH,    16'd0, 8'h00, 48'd0, 32'd0,          1, ST_MISMATCH, 32'd0},
    // 64 blocks of 512 bytes, 30 used
    '{FUNC_LOAD,      16'd0, 8'h01, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_LOAD,      16'd1, 8'hFF, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_LOAD,      16'd2, 8'h00, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_LOAD,      16'd3, 8'h80, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_LOAD,      16'd4, 8'hAA, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_LOAD,      16'd5, 8'h55, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_LOAD,      16'd6, 8'hFF, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_LOAD,      16'd7, 8'h0F, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_FINISH,    16'd0, 8'h00, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_TRANSLATE, 16'd0, 8'h00, 48'd0, 32'd1,          0, ST_ACCEPTED, 32'd0},
    '{FUNC_TRANSLATE, 16'd0, 8'h00, 48'd511, 32'hFFFFFFFF, 0, ST_ACCEPTED, 32'd0},
    '{FUNC_TRANSLATE, 16'd0, 8'h00, 48'd32768, 32'd100,    1, ST_ZERO,     32'd100},
    '{FUNC_TRANSLATE, 16'd0, 8'h00, 48'd8192, 32'd600,     0, ST_ACCEPTED, 32'd0},
    '{FUNC_TRANSLATE, 16'd0, 8'h00, 48'd32261, 32'd1000,   0, ST_ACCEPTED, 32'd0},
    '{FUNC_TRANSLATE, 16'd0, 8'h00, M48,   32'd0,          1, ST_ACCEPTED, 32'd0},
    '{FUNC_TRANSLATE, 16'd0, 8'h00, M48,   32'd1,          1, ST_RANGE,    32'd0},
    '{FUNC_LOAD,      16'hFFFF, 8'hA5, 48'd0, 32'd0,       1, ST_ACCEPTED, 32'd0},
    '{FUNC_FINISH,    16'd0, 8'h00, 48'd0, 32'd0,          1, ST_ACCEPTED, 32'd0}
  };

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Used blocks strictly below blk: checkpoint plus partial byte counts
  function automatic logic [19:0] rank_below(input longint unsigned blk, inout bit unsafe);
    longint unsigned grp;
    longint unsigned b;
    longint unsigned lo;
    longint unsigned hi;
    logic [7:0]      m;
    logic [19:0]     r;
    grp = blk / GROUP;
    lo  = (grp * GROUP) >> 3;
    hi  = blk >> 3;
    if (!ckpt_written[grp]) unsafe = 1;
    r = ckpt_mirror[grp];
    for (b = lo; b <= hi; b++) begin
      m = 8'hFF;
      if (b == hi) m = 8'((9'd1 << blk[2:0]) - 9'd1);
      if (!bm_written[b]) unsafe = 1;
      r = r + 20'($countones(bm_mirror[b] & m));
    end
    return r;
  endfunction

  // Expected result of one item; loads update the mirror
  function automatic xlate_t predict_item(input logic [1:0] f, input logic [15:0] idx,
                                          input logic [7:0] bt, input logic [47:0] off,
                                          input logic [31:0] len, output bit unsafe);
    xlate_t          r;
    longint unsigned logical;
    longint unsigned offv;
    longint unsigned blk;
    longint unsigned inb;
    longint unsigned rest;
    longint unsigned sb;
    longint unsigned pos;
    longint unsigned strip;
    longint unsigned bps;
    longint unsigned blkn;
    logic [7:0]      byte_v;
    bit              used_bit;
    r      = '0;
    unsafe = 0;
    offv   = off;
    case (f)
      FUNC_LOAD: begin
        if (idx == 0) used_count = '0;
        bm_mirror[idx]  = bt;
        bm_written[idx] = 1;
        for (int k = 0; k < 8; k++) begin
          blkn = longint'(idx) * 8 + k;
          if (blkn >= c_tblk) break;
          if (blkn % GROUP == 0) begin
            ckpt_mirror[blkn / GROUP]  = used_count;
            ckpt_written[blkn / GROUP] = 1;
          end
          if (bt[k]) used_count = used_count + 20'd1;
        end
        r.status = ST_ACCEPTED;
      end
      FUNC_FINISH: r.status = (used_count == c_used) ? ST_ACCEPTED : ST_MISMATCH;
      FUNC_TRANSLATE: begin
        logical = longint'(c_tblk) * c_bsize;
        if (off > c_tbytes || len > c_tbytes - off) begin
          r.status = ST_RANGE;
        end else if (len == 0) begin
          r.status = ST_ACCEPTED;
        end else if (offv >= logical) begin
          r.status = ST_ZERO;
          r.count  = len;
        end else begin
          blk     = offv / c_bsize;
          inb     = offv % c_bsize;
          rest    = c_bsize - inb;
          r.count = (len < rest) ? len : 32'(rest);
          used_bit = 0;
          if ((blk >> 3) < STORE) begin
            if (!bm_written[blk >> 3]) unsafe = 1;
            byte_v   = bm_mirror[blk >> 3];
            used_bit = byte_v[blk[2:0]];
          end
          if (!used_bit) begin
            r.status = ST_ZERO;
          end else begin
            sb       = rank_below(blk, unsafe);
            r.status = ST_STORED;
            case (c_layout)
              LAYOUT_PER_BLOCK: begin
                pos   = c_doff + sb * (longint'(c_bsize) + c_tsz);
                strip = sb;
              end
              LAYOUT_PER_STRIP: begin
                bps   = (c_bps == 0) ? 1 : c_bps;
                strip = sb / bps;
                pos   = c_doff + sb * c_bsize + strip * c_tsz;
              end
              default: begin
                pos   = c_doff + sb * c_bsize;
                strip = 0;
              end
            endcase
            r.soff  = 48'(pos + inb);
            r.sblk  = 19'(sb);
            r.strip = 19'(strip);
          end
        end
      end
      default: r.status = ST_RANGE;
    endcase
    return r;
  endfunction

  // Present one item, hold it until the transfer, then queue its result
  task automatic send_item(input logic [1:0] f, input logic [15:0] idx, input logic [7:0] bt,
                           input logic [47:0] off, input logic [31:0] len, input xlate_t exp_r);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= f;
    bitmap_index_i   <= idx;
    bitmap_byte_i    <= bt;
    byte_offset_i    <= off;
    request_length_i <= len;
    do @(posedge clk_i); while (!in_ready_o);
    pending_xlate.push_back(exp_r);
  endtask

  task automatic issue(input logic [1:0] f, input logic [15:0] idx, input logic [7:0] bt,
                       input logic [47:0] off, input logic [31:0] len);
    xlate_t r;
    bit     unsafe;
    r = predict_item(f, idx, bt, off, len, unsafe);
    send_item(f, idx, bt, off, len, r);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_xlate.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // APB write: setup, access, then release
  task automatic cfg_write(input logic [2:0] ridx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ridx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (ridx)
      REG_TOTAL_BYTES:  c_tbytes = val[47:0];
      REG_BLOCK_SIZE:   c_bsize  = val[26:0];
      REG_TOTAL_BLOCKS: c_tblk   = val[19:0];
      REG_USED_BLOCKS:  c_used   = val[19:0];
      REG_DATA_OFFSET:  c_doff   = val[47:0];
      REG_LAYOUT_MODE:  c_layout = val[1:0];
      REG_TRAILER_SIZE: c_tsz    = val[3:0];
      default:          c_bps    = val[19:0];
    endcase
    @(posedge clk_i);
  endtask

  // Result side: random ready bursts, steady in the last part
  always @(posedge clk_i) begin
    if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 9) < 7);
      rdy_hold    <= $urandom_range(0, 18);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_xlate.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d", $time, status_o);
        errors++;
      end else begin
        head = pending_xlate.pop_front();
        check_field("status", head.status, status_o);
        check_field("byte_count", head.count, byte_count_o);
        check_field("stored_offset", head.soff, stored_offset_o);
        check_field("stored_block", head.sblk, stored_block_o);
        check_field("strip_index", head.strip, strip_index_o);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WD_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int              tb_load;
    int              nb;
    int              dens;
    int              sel;
    int              tries;
    longint unsigned lb;
    longint unsigned blk;
    longint unsigned offv;
    logic [47:0]     off;
    logic [31:0]     len;
    logic [1:0]      f;
    logic [7:0]      bt;
    logic [19:0]     used_w;
    logic [26:0]     bsize;
    logic [47:0]     tbytes;
    xlate_t          r;
    bit              unsafe;
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid_i       <= 1'b0;
    func_i           <= '0;
    bitmap_index_i   <= '0;
    bitmap_byte_i    <= '0;
    byte_offset_i    <= '0;
    request_length_i <= '0;
    out_ready_i      <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < ROWS; i++) begin
      if (i == SPLIT) begin
        drain();
        cfg_write(REG_TOTAL_BYTES, M48);
        cfg_write(REG_BLOCK_SIZE, 64'd512);
        cfg_write(REG_TOTAL_BLOCKS, 64'd64);
        cfg_write(REG_USED_BLOCKS, 64'd30);
      end
      r = predict_item(plan[i].f, plan[i].idx, plan[i].bt, plan[i].off, plan[i].len, unsafe);
      if (plan[i].typed) r = '{status: plan[i].st, count: plan[i].cnt, default: '0};
      send_item(plan[i].f, plan[i].idx, plan[i].bt, plan[i].off, plan[i].len, r);
    end

    // Random phases: configure, load ascending, finish, translate
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      quiet = (ph == 9);
      case (ph)
        1:       tb_load = 4200;
        3:       tb_load = 8;
        default: tb_load = $urandom_range(1, 1000);
      endcase
      case (ph % 5)
        0:       bsize = 27'd512;
        1:       bsize = 27'd1;
        2:       bsize = 27'($urandom_range(2, 1 << 26));
        3:       bsize = 27'(1 << 26);
        default: bsize = 27'd4096;
      endcase
      if (ph == 7) bsize = '0;
      case (ph % 3)
        0:       tbytes = M48;
        1:       tbytes = 48'(longint'(tb_load) * bsize);
        default: tbytes = 48'(longint'(tb_load) * bsize + $urandom_range(0, 5000));
      endcase
      if (bsize == 0) tbytes = M48;
      cfg_write(REG_TOTAL_BYTES, tbytes);
      cfg_write(REG_BLOCK_SIZE, bsize);
      cfg_write(REG_TOTAL_BLOCKS, tb_load);
      cfg_write(REG_DATA_OFFSET, (ph % 4 == 3) ? M48 : 48'({$urandom, $urandom}));
      cfg_write(REG_LAYOUT_MODE, ph % 4);
      cfg_write(REG_TRAILER_SIZE, (ph % 3 == 0) ? 8 : (ph % 3 == 1) ? 0 : $urandom_range(0, 8));
      case (ph % 4)
        0:       cfg_write(REG_BPS, 0);
        1:       cfg_write(REG_BPS, 1);
        2:       cfg_write(REG_BPS, $urandom_range(1, 40));
        default: cfg_write(REG_BPS, 524288);
      endcase

      // Load the bitmap with an occasional stray byte
      dens = $urandom_range(0, 2);
      nb   = (tb_load + 7) / 8;
      for (int i = 0; i < nb; i++) begin
        case (dens)
          0:       bt = 8'($urandom);
          1:       bt = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'hFF;
          default: bt = 8'($urandom) & 8'($urandom) & 8'($urandom);
        endcase
        if ($urandom_range(0, 40) == 0)
          issue(FUNC_LOAD, 16'($urandom_range(1, 65535)), 8'($urandom), 48'($urandom), $urandom);
        issue(FUNC_LOAD, 16'(i), bt, 48'({$urandom, $urandom}), $urandom);
      end

      drain();
      used_w = (ph == 2) ? 20'd0 : (ph == 4) ? 20'd524288 :
               ($urandom_range(0, 3) == 0) ? used_count + 20'd1 : used_count;
      cfg_write(REG_USED_BLOCKS, used_w);
      issue(FUNC_FINISH, 16'($urandom), 8'($urandom), 48'({$urandom, $urandom}), $urandom);

      // Widen the logical range past what was loaded
      if (ph == 5 || ph == 6) begin
        drain();
        cfg_write(REG_TOTAL_BLOCKS, (ph == 5) ? 524288 : 20'hFFFFF);
        cfg_write(REG_TOTAL_BYTES, M48);
      end

      lb = (longint'(nb) * 8 < c_tblk) ? longint'(nb) * 8 : c_tblk;
      for (int t = 0; t < 70; t++) begin
        tries = 0;
        do begin
          sel  = $urandom_range(0, 9);
          len  = $urandom;
          offv = 48'({$urandom, $urandom});
          case (sel)
            0, 1, 2, 3, 4: begin
              blk  = $urandom_range(0, 32'(lb - 1));
              offv = blk * c_bsize + ((c_bsize > 1) ? $urandom_range(0, c_bsize - 1) : 0);
              case ($urandom_range(0, 3))
                0:       len = 32'd1;
                1:       len = $urandom_range(1, 2 * c_bsize + 1);
                2:       len = $urandom;
                default: len = 32'hFFFFFFFF;
              endcase
            end
            5:       offv = longint'(c_tblk) * c_bsize + $urandom_range(0, 3000);
            6: begin
              offv = c_tbytes - $urandom_range(0, 3);
              len  = $urandom_range(0, 5);
            end
            7: begin
              offv = longint'($urandom_range(0, 32'(lb - 1))) * c_bsize;
              len  = '0;
            end
            default: ;
          endcase
          off = 48'(offv);
          f   = ($urandom_range(0, 30) == 0) ? FUNC_SPARE : FUNC_TRANSLATE;
          r   = predict_item(f, 16'($urandom), 8'($urandom), off, len, unsafe);
          tries++;
        end while (unsafe && tries < 30);
        if (unsafe) begin
          f = FUNC_SPARE;
          r = predict_item(f, 16'($urandom), 8'($urandom), off, len, unsafe);
        end
        send_item(f, 16'($urandom), 8'($urandom), off, len, r);
      end
    end

    // Wait out the last results
    in_valid_i <= 1'b0;
    while (pending_xlate.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sparse_image_block_translator.f]
hdl/sibt_pkg.sv
hdl/sibt_div.sv
hdl/sparse_image_block_translator.sv
tb/tb_sparse_image_block_translator.sv
